// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// ===== rtl/core/vafa_pkg.sv =====
package vafa_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW = 3;
  localparam int unsigned DestW = 4;
  localparam int unsigned AmtW = 8;
  localparam int unsigned ShW = 5;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;

  typedef enum logic [2:0] {
    OP_FADD = 3'd0,
    OP_IADD = 3'd1,
    OP_OR   = 3'd2,
    OP_AND  = 3'd3,
    OP_XOR  = 3'd4,
    OP_ROR  = 3'd5
  } op_e;

  // Aligned operands, after unpack and alignment shift.
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        eff_sub;
    logic        sign;
    logic        sgn_b;
    logic [7:0]  exp;
    logic [26:0] ma;
    logic [26:0] mb;
  } fa_align_t;

  // Raw sum, before normalization.
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        eff_sub;
    logic        sign;
    logic        sgn_b;
    logic [7:0]  exp;
    logic [27:0] sum;
  } fa_sum_t;

  // Normalized sum, before rounding.
  typedef struct packed {
    logic        special;
    logic [31:0] special_val;
    logic        sign;
    logic [8:0]  exp;
    logic [26:0] sum;
  } fa_norm_t;

  function automatic logic [26:0] shr_sticky(input logic [26:0] v, input logic [7:0] d);
    logic [26:0] r;
    logic        st;
    begin
      if (d == 8'd0) begin
        r = v;
      end else if (d >= 8'd27) begin
        r = {26'd0, |v};
      end else begin
        st = |(v & ((27'd1 << d[4:0]) - 27'd1));
        r = (v >> d[4:0]) | {26'd0, st};
      end
      return r;
    end
  endfunction
endpackage

// ===== rtl/core/vafa_align.sv =====
// Stage 1: unpack, special cases, order by magnitude, align the smaller operand.
module vafa_align import vafa_pkg::*; (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output fa_align_t   align_o
);
  logic [7:0]  ea, eb, exa, exb;
  logic [22:0] fa, fb;
  logic        swap;
  logic [31:0] x, y;
  logic [23:0] mx, my;

  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    fa = a_i[22:0];
    fb = b_i[22:0];
    swap = a_i[30:0] < b_i[30:0];
    x = swap ? b_i : a_i;
    y = swap ? a_i : b_i;
    mx = (x[30:23] == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    my = (y[30:23] == 8'd0) ? {1'b0, y[22:0]} : {1'b1, y[22:0]};
    exa = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    exb = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    align_o.special = 1'b1;
    align_o.special_val = 32'd0;
    if (ea == 8'hFF && fa != 23'd0) begin
      align_o.special_val = a_i | 32'h0040_0000;
    end else if (eb == 8'hFF && fb != 23'd0) begin
      align_o.special_val = b_i | 32'h0040_0000;
    end else if (ea == 8'hFF) begin
      align_o.special_val = (eb == 8'hFF && a_i[31] != b_i[31]) ? DefaultNan : a_i;
    end else if (eb == 8'hFF) begin
      align_o.special_val = b_i;
    end else begin
      align_o.special = 1'b0;
    end
    align_o.eff_sub = x[31] ^ y[31];
    align_o.sign = x[31];
    align_o.sgn_b = y[31];
    align_o.exp = exa;
    align_o.ma = {mx, 3'b000};
    align_o.mb = shr_sticky({my, 3'b000}, exa - exb);
  end
endmodule

// ===== rtl/core/vafa_norm.sv =====
// Stage 3: normalize the raw sum. Leading-zero count replaces the shift loop.
module vafa_norm import vafa_pkg::*; (
  input  fa_sum_t  sum_i,
  output fa_norm_t norm_o
);
  logic [4:0]  lz;
  logic [4:0]  sh;
  logic [27:0] s;

  always_comb begin
    s = sum_i.sum;
    lz = 5'd0;
    sh = 5'd0;
    for (int i = 0; i <= 26; i++) begin
      if (s[i]) lz = 5'(26 - i);
    end
    norm_o.special = sum_i.special;
    norm_o.special_val = sum_i.special_val;
    norm_o.sign = sum_i.sign;
    norm_o.exp = {1'b0, sum_i.exp};
    norm_o.sum = s[26:0];
    if (!sum_i.special) begin
      if (s == 28'd0) begin
        norm_o.special = 1'b1;
        norm_o.special_val = sum_i.eff_sub ? 32'd0 : {sum_i.sign, 31'd0};
      end else if (!sum_i.eff_sub) begin
        if (s[27]) begin
          norm_o.sum = s[27:1] | {26'd0, s[0]};
          norm_o.exp = {1'b0, sum_i.exp} + 9'd1;
        end
      end else begin
        // shift left while exponent stays above one
        sh = ({3'd0, lz} > 8'(sum_i.exp - 8'd1)) ? 5'(sum_i.exp - 8'd1) : lz;
        norm_o.sum = s[26:0] << sh;
        norm_o.exp = {1'b0, sum_i.exp} - {4'd0, sh};
      end
    end
  end
endmodule

// ===== rtl/core/vafa_round.sv =====
// Stage 4: round to nearest even and pack.
module vafa_round import vafa_pkg::*; (
  input  fa_norm_t    norm_i,
  output logic [31:0] value_o
);
  logic [24:0] rnd;
  logic [2:0]  rem;
  logic [8:0]  e;

  always_comb begin
    rnd = {1'b0, norm_i.sum[26:3]};
    rem = norm_i.sum[2:0];
    e = norm_i.exp;
    if (rem > 3'd4 || (rem == 3'd4 && rnd[0])) rnd = rnd + 25'd1;
    if (rnd[24]) begin
      rnd = rnd >> 1;
      e = e + 9'd1;
    end
    if (norm_i.special) begin
      value_o = norm_i.special_val;
    end else if (e >= 9'd255) begin
      value_o = {norm_i.sign, 31'h7F80_0000};
    end else begin
      value_o = {norm_i.sign, (rnd[23] ? e[7:0] : 8'd0), rnd[22:0]};
    end
  end
endmodule

// ===== rtl/core/vole_alu_with_float_add_core.sv =====
// Pipelined ALU: float add, integer add, OR, AND, XOR, rotate right.
// One item enters per cycle unless the output stalls; each result passes the
// align, add, normalize and round/pack registers after its item is accepted.
// A stall of the output freezes the whole pipe; items are never lost or repeated.
// tdata in:  operation[2:0], first_value[34:3], second_value[66:35],
//            dest_index[70:67], rotate_amount[78:71], zero fill to 80 bits.
// tdata out: result_dest[3:0], result_value[35:4], zero fill to 40 bits.
`include "assert_macros.svh"
module vole_alu_with_float_add_core import vafa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // operation, first_value, second_value, dest_index, rotate_amount
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_dest, result_value
);
  localparam int unsigned NStg = 4;

  logic        adv;
  logic [NStg-1:0] vld_q;

  logic [2:0]  op_in;
  logic [31:0] a_in, b_in;
  logic [3:0]  dst_in;
  logic [7:0]  amt_in;

  fa_align_t   align_d, align_q;
  fa_sum_t     sum_d, sum_q;
  fa_norm_t    norm_d, norm_q;
  logic [31:0] fval;
  logic [31:0] int_d;
  logic [31:0] int_q [NStg-1];
  logic        isf_q [NStg-1];
  logic [3:0]  dst_q [NStg];
  logic [31:0] res_q;
  logic        isf_last;

  assign op_in  = s_axis_tdata[2:0];
  assign a_in   = s_axis_tdata[34:3];
  assign b_in   = s_axis_tdata[66:35];
  assign dst_in = s_axis_tdata[70:67];
  assign amt_in = s_axis_tdata[78:71];

  assign adv = !vld_q[NStg-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_comb begin
    case (op_e'(op_in))
      OP_IADD: int_d = a_in + b_in;
      OP_OR:   int_d = a_in | b_in;
      OP_AND:  int_d = a_in & b_in;
      OP_XOR:  int_d = a_in ^ b_in;
      OP_ROR:  int_d = (a_in >> amt_in[ShW-1:0]) |
                       (a_in << (6'd32 - {1'b0, amt_in[ShW-1:0]}));
      default: int_d = 32'd0;
    endcase
    if (amt_in[ShW-1:0] == 5'd0 && op_e'(op_in) == OP_ROR) int_d = a_in;
  end

  vafa_align u_align (.a_i(a_in), .b_i(b_in), .align_o(align_d));

  always_comb begin
    sum_d.special = align_q.special;
    sum_d.special_val = align_q.special_val;
    sum_d.eff_sub = align_q.eff_sub;
    sum_d.sign = align_q.sign;
    sum_d.sgn_b = align_q.sgn_b;
    sum_d.exp = align_q.exp;
    sum_d.sum = align_q.eff_sub ? ({1'b0, align_q.ma} - {1'b0, align_q.mb})
                                : ({1'b0, align_q.ma} + {1'b0, align_q.mb});
  end

  vafa_norm  u_norm  (.sum_i(sum_q), .norm_o(norm_d));
  vafa_round u_round (.norm_i(norm_q), .value_o(fval));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid};
    end
  end

  assign isf_last = isf_q[NStg-2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      align_q  <= align_d;
      sum_q    <= sum_d;
      norm_q   <= norm_d;
      int_q[0] <= int_d;
      isf_q[0] <= (op_e'(op_in) == OP_FADD);
      dst_q[0] <= dst_in;
      for (int i = 1; i < NStg - 1; i++) begin
        int_q[i] <= int_q[i-1];
        isf_q[i] <= isf_q[i-1];
      end
      for (int i = 1; i < NStg; i++) dst_q[i] <= dst_q[i-1];
      res_q <= isf_last ? fval : int_q[NStg-2];
    end
  end

  assign m_axis_tvalid = vld_q[NStg-1];
  assign m_axis_tdata  = {4'd0, res_q, dst_q[NStg-1]};

  `ASSERT_CLK(a_stall_hold, clk_i, rst_ni,
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q) && $stable(res_q))
  `ASSERT_CLK(a_ready_when_empty, clk_i, rst_ni, !vld_q[NStg-1] |-> s_axis_tready)
  `ASSERT_CLK(a_latency, clk_i, rst_ni,
    (s_axis_tvalid && s_axis_tready && m_axis_tready) |=> vld_q[0])
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import vafa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned PipeDepth = 4;
  localparam int unsigned OpUnused = 6;

  // Lowest field last, so the packed layout matches tdata.
  typedef struct packed {
    logic [7:0]  amount;
    logic [3:0]  dest;
    logic [31:0] word_b;
    logic [31:0] word_a;
    logic [2:0]  opcode;
  } alu_cmd_t;

  typedef struct packed {
    logic [3:0]  dest;
    logic [31:0] value;
  } alu_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;   // operation, first_value, second_value, dest_index, rotate_amount
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // result_dest, result_value

  alu_cmd_t cmd_q[$];
  alu_res_t result_q[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_off;
  bit          in_fire;
  int unsigned mismatch_cnt;
  int unsigned quiet_cycles;
  alu_cmd_t    cur_cmd;

  vole_alu_with_float_add_core u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sticky_shr(input logic [31:0] v, input logic [31:0] d);
    if (d == 0) return v;
    if (d >= 31) return {31'd0, v != 0};
    return (v >> d) | {31'd0, (v & ((32'd1 << d) - 1)) != 0};
  endfunction

  function automatic logic [31:0] fp_sum(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ea, eb, fa, fb, ma, mb, acc, e, rnd, rem, t;
    logic        sa, sb, ts;
    ea = {24'd0, a[30:23]};
    eb = {24'd0, b[30:23]};
    fa = {9'd0, a[22:0]};
    fb = {9'd0, b[22:0]};
    sa = a[31];
    sb = b[31];
    if (ea == 255 && fa != 0) return a | 32'h0040_0000;
    if (eb == 255 && fb != 0) return b | 32'h0040_0000;
    if (ea == 255) return (eb == 255 && sa != sb) ? DefaultNan : a;
    if (eb == 255) return b;
    if (a[30:0] < b[30:0]) begin
      t = ea; ea = eb; eb = t;
      t = fa; fa = fb; fb = t;
      ts = sa; sa = sb; sb = ts;
    end
    ma = (ea == 0) ? fa : (fa | 32'h0080_0000);
    mb = (eb == 0) ? fb : (fb | 32'h0080_0000);
    if (ea == 0) ea = 1;
    if (eb == 0) eb = 1;
    ma = ma << 3;
    mb = sticky_shr(mb << 3, ea - eb);
    e = ea;
    if (sa == sb) begin
      acc = ma + mb;
      if (acc == 0) return {sa, 31'd0};
      if (acc >= (32'd1 << 27)) begin
        acc = sticky_shr(acc, 1);
        e++;
      end
    end else begin
      acc = ma - mb;
      if (acc == 0) return 32'd0;
      while (acc < (32'd1 << 26) && e > 1) begin
        acc = acc << 1;
        e--;
      end
    end
    rnd = acc >> 3;
    rem = acc & 7;
    if (rem > 4 || (rem == 4 && rnd[0])) rnd++;
    if (rnd >= (32'd1 << 24)) begin
      rnd = rnd >> 1;
      e++;
    end
    if (e >= 255) return {sa, 31'h7F80_0000};
    return {sa, (rnd[23] ? e[7:0] : 8'd0), rnd[22:0]};
  endfunction

  function automatic alu_res_t alu_result(input alu_cmd_t c);
    alu_res_t r;
    r.dest = c.dest;
    case (c.opcode)
      OP_FADD: r.value = fp_sum(c.word_a, c.word_b);
      OP_IADD: r.value = c.word_a + c.word_b;
      OP_OR:   r.value = c.word_a | c.word_b;
      OP_AND:  r.value = c.word_a & c.word_b;
      OP_XOR:  r.value = c.word_a ^ c.word_b;
      OP_ROR:  r.value = (c.word_a >> c.amount[4:0]) |
                         (c.word_a << ((32 - c.amount[4:0]) % 32));
      default: r.value = 32'd0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:23] = 8'hFF;
      1: w[30:23] = 8'h00;
      2: w[30:23] = 8'hFE;
      3: w[22:0] = 23'd0;
      default: w[30:23] = 8'd120 + 8'($urandom_range(0, 16));
    endcase
    return w;
  endfunction

  function automatic alu_cmd_t make_cmd(input logic [2:0] op, input logic [31:0] a,
                                        input logic [31:0] b, input logic [7:0] amt);
    alu_cmd_t c;
    c.opcode = op;
    c.word_a = a;
    c.word_b = b;
    c.dest = 4'($urandom);
    c.amount = amt;
    return c;
  endfunction

  // Driver: present the head of the pending queue.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) void'(cmd_q.pop_front());
      if (!s_axis_tvalid || in_fire) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = cmd_q[0];
          s_axis_tdata <= {1'b0, cur_cmd.amount, cur_cmd.dest, cur_cmd.word_b,
                           cur_cmd.word_a, cur_cmd.opcode};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on input accept, compare on output accept.
  always @(posedge clk_i) begin
    alu_res_t want;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) result_q.push_back(alu_result(s_axis_tdata[78:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata[35:4], 32'd0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata[3:0] !== want.dest)
            report_mismatch("result_dest", 32'(m_axis_tdata[3:0]), 32'(want.dest));
          if (m_axis_tdata[35:4] !== want.value)
            report_mismatch("result_value", m_axis_tdata[35:4], want.value);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering items.
  initial begin
    hold_off = 1'b0;
    wait (cmd_q.size() > 300 && rst_ni);
    repeat (200) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    logic [31:0] edge_words[10];
    int unsigned phase;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    edge_words = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001,
                   32'hFF80_0123, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                   32'hFFFF_FFFF};

    // Directed: float corners, every opcode, unused codes, rotate extremes.
    cmd_q.push_back(make_cmd(OP_FADD, 32'h8000_0000, 32'h8000_0000, 8'd0));
    cmd_q.push_back(make_cmd(OP_FADD, 32'h7F80_0000, 32'hFF80_0000, 8'd0));
    cmd_q.push_back(make_cmd(OP_FADD, 32'h7F80_0001, 32'hFFC0_0000, 8'd0));
    cmd_q.push_back(make_cmd(OP_FADD, 32'h3F80_0000, 32'hFF80_0005, 8'd0));
    cmd_q.push_back(make_cmd(OP_FADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 8'd0));
    cmd_q.push_back(make_cmd(OP_FADD, 32'h3F80_0000, 32'hBF80_0000, 8'd0));
    cmd_q.push_back(make_cmd(OP_FADD, 32'h0000_0001, 32'h807F_FFFF, 8'd0));
    cmd_q.push_back(make_cmd(OP_FADD, 32'h3F80_0000, 32'h3380_0000, 8'd0));
    cmd_q.push_back(make_cmd(OP_FADD, 32'h0040_0000, 32'h0040_0000, 8'd0));
    cmd_q.push_back(make_cmd(OP_IADD, 32'hFFFF_FFFF, 32'h0000_0001, 8'd0));
    cmd_q.push_back(make_cmd(OP_OR, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 8'd0));
    cmd_q.push_back(make_cmd(OP_AND, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'd0));
    cmd_q.push_back(make_cmd(OP_XOR, 32'hFFFF_FFFF, 32'h0000_0000, 8'd255));
    cmd_q.push_back(make_cmd(OP_ROR, 32'h8000_0001, 32'hFFFF_FFFF, 8'd0));
    cmd_q.push_back(make_cmd(OP_ROR, 32'h8000_0001, 32'h0, 8'd32));
    cmd_q.push_back(make_cmd(OP_ROR, 32'h1234_5678, 32'h0, 8'd31));
    cmd_q.push_back(make_cmd(OP_ROR, 32'h1234_5678, 32'h0, 8'd255));
    cmd_q.push_back(make_cmd(3'(OpUnused), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255));
    cmd_q.push_back(make_cmd(3'd7, 32'h1, 32'h1, 8'd1));

    // Random items across five phases of send idling and receive stalls.
    for (int i = 0; i < 1100; i++) begin
      logic [2:0] op;
      logic [31:0] a, b;
      op = ($urandom_range(0, 9) < 5) ? 3'(OP_FADD) : 3'($urandom_range(0, 7));
      if (op == OP_FADD) begin
        a = rand_float();
        b = $urandom_range(0, 3) == 0 ? (a ^ {1'b1, 31'($urandom_range(0, 7))}) : rand_float();
        if ($urandom_range(0, 15) == 0) b = edge_words[$urandom_range(0, 9)];
      end else begin
        a = $urandom;
        b = $urandom;
      end
      cmd_q.push_back(make_cmd(op, a, b, 8'($urandom)));
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        3: begin send_idle_pct = 27; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      wait (cmd_q.size() <= 1120 - 240 * (phase + 1) || cmd_q.size() == 0);
    end
    wait (cmd_q.size() == 0 && !s_axis_tvalid);
    wait (result_q.size() == 0);
    repeat (PipeDepth * 4) @(posedge clk_i);
    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/vafa_pkg.sv
rtl/core/vafa_align.sv
rtl/core/vafa_norm.sv
rtl/core/vafa_round.sv
rtl/core/vole_alu_with_float_add_core.sv
tb/tb_top.sv
